FILE: sv/process_scheduler_event_engine_top_defines.svh
// Assertion macros for the process scheduler event engine.
// Used by the top level only; no other dependencies.
`ifndef PROCESS_SCHEDULER_EVENT_ENGINE_TOP_DEFINES_SVH
`define PROCESS_SCHEDULER_EVENT_ENGINE_TOP_DEFINES_SVH

// Implication checked on every rising clock edge outside reset.
`define PSE_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset.
`define PSE_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/pse_pkg.sv
// Shared types and constants for the process scheduler event engine.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package pse_pkg;
    localparam logic [3:0] REQ_DISPATCH = 4'd0;
    localparam logic [3:0] REQ_TICK     = 4'd1;
    localparam logic [3:0] REQ_SPAWN    = 4'd2;
    localparam logic [3:0] REQ_GETPID   = 4'd3;
    localparam logic [3:0] REQ_GETTIME  = 4'd4;
    localparam logic [3:0] REQ_SLEEP    = 4'd5;
    localparam logic [3:0] REQ_FORK     = 4'd6;
    localparam logic [3:0] REQ_LOCK     = 4'd7;
    localparam logic [3:0] REQ_UNLOCK   = 4'd8;
    localparam logic [3:0] REQ_EXIT     = 4'd9;
    localparam logic [3:0] REQ_WAIT     = 4'd10;

    localparam logic [2:0] ST_FREE    = 3'd0;
    localparam logic [2:0] ST_READY   = 3'd1;
    localparam logic [2:0] ST_RUN     = 3'd2;
    localparam logic [2:0] ST_SLEEP   = 3'd3;
    localparam logic [2:0] ST_SUSPEND = 3'd4;
    localparam logic [2:0] ST_WAIT    = 3'd5;
    localparam logic [2:0] ST_ZOMBIE  = 3'd6;

    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_NO_FREE = 2'd1;
    localparam logic [1:0] STAT_BAD_MTX = 2'd2;
    localparam logic [1:0] STAT_NO_RUN  = 2'd3;

    localparam logic [0:0] CFG_SLICE = 1'b0;
    localparam logic [0:0] CFG_SCALE = 1'b1;

    localparam logic [15:0] SLICE_RESET = 16'd5;
    localparam logic [7:0]  SCALE_RESET = 8'd10;

    // Datapath operations issued by the controller.
    typedef enum logic [3:0] {
        OP_NONE, OP_LATCH, OP_DISPATCH, OP_TICK_CHARGE, OP_SCAN, OP_PREEMPT,
        OP_SPAWN, OP_SYSCALL, OP_WAIT_SCAN, OP_REQUEUE, OP_FINISH
    } op_t;

    typedef struct packed {
        op_t op;
    } pse_cmd_t;

    typedef struct packed {
        logic scan_last;   // scan index at final entry
        logic scan_hit;    // wait scan found a zombie child
        logic running;     // a process is running
    } pse_stat_t;
endpackage
`default_nettype wire

FILE: sv/pse_ctrl.sv
// Controller state machine for the process scheduler event engine.
// Depends on pse_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pse_ctrl (
    input  wire               aclk,
    input  wire               aresetn,
    input  wire               in_valid,
    output logic              in_ready,
    input  wire  [3:0]        req,
    output logic              out_valid,
    input  wire               out_ready,
    input  wire  pse_pkg::pse_stat_t stat,
    output pse_pkg::pse_cmd_t cmd
);
    import pse_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;
    localparam logic [2:0] S_PRE  = 3'd3;
    localparam logic [2:0] S_WSCN = 3'd4;
    localparam logic [2:0] S_REQ  = 3'd5;
    localparam logic [2:0] S_DONE = 3'd6;
    localparam logic [2:0] S_WEND = 3'd7;

    logic [2:0] state_reg, state_next;
    logic [3:0] req_reg, req_next;
    logic       valid_reg, valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
        req_reg <= req_next;
    end

    // The output register holds a waiting result; only S_DONE waits on it.
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = valid_reg;

    always_comb begin
        state_next = state_reg;
        req_next   = req_reg;
        valid_next = valid_reg;
        cmd.op     = OP_NONE;
        if (valid_reg && out_ready) valid_next = 1'b0;
        case (state_reg)
            S_IDLE: begin
                if (in_valid && in_ready) begin
                    cmd.op     = OP_LATCH;
                    req_next   = req;
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                state_next = S_DONE;
                if (req_reg == REQ_DISPATCH) cmd.op = OP_DISPATCH;
                else if (req_reg == REQ_TICK) begin
                    cmd.op = OP_TICK_CHARGE;
                    state_next = S_SCAN;
                end else if (req_reg == REQ_SPAWN) cmd.op = OP_SPAWN;
                else if (req_reg > REQ_WAIT) state_next = S_DONE;
                else if (!stat.running) cmd.op = OP_SYSCALL;
                else if (req_reg == REQ_WAIT) begin
                    cmd.op = OP_WAIT_SCAN;
                    state_next = S_WSCN;
                end else begin
                    cmd.op = OP_SYSCALL;
                    state_next = S_REQ;
                end
            end
            S_SCAN: begin
                cmd.op = OP_SCAN;
                if (stat.scan_last) state_next = S_PRE;
            end
            S_PRE: begin
                cmd.op = OP_PREEMPT;
                state_next = S_DONE;
            end
            S_WSCN: begin
                if (stat.scan_hit) begin
                    cmd.op = OP_SYSCALL;
                    state_next = S_REQ;
                end else begin
                    // check the final entry too before giving up
                    cmd.op = OP_WAIT_SCAN;
                    if (stat.scan_last) state_next = S_WEND;
                end
            end
            S_WEND: begin
                cmd.op = OP_SYSCALL;
                state_next = S_REQ;
            end
            S_REQ: begin
                cmd.op = OP_REQUEUE;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (!valid_reg || out_ready) begin
                    cmd.op = OP_FINISH;
                    valid_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end
endmodule
`default_nettype wire

FILE: sv/pse_dp.sv
// Datapath: process table, FIFOs, tick counter and result register.
// Depends on pse_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pse_dp #(
    parameter int NUM_PROCS = 32
) (
    input  wire               aclk,
    input  wire               aresetn,
    input  pse_pkg::pse_cmd_t cmd,
    output pse_pkg::pse_stat_t stat,
    input  wire  [3:0]        req,
    input  wire  [31:0]       arg,
    input  wire               cfg_we,
    input  wire  [0:0]        cfg_addr,
    input  wire  [15:0]       cfg_wdata,
    output logic [1:0]        o_status,
    output logic [31:0]       o_ret_value,
    output logic [5:0]        o_ret_pid,
    output logic [31:0]       o_exit_value,
    output logic [5:0]        o_released_parent,
    output logic [5:0]        o_running_id
);
    import pse_pkg::*;

    localparam int IW = (NUM_PROCS > 1) ? $clog2(NUM_PROCS) : 1;
    localparam int CW = IW + 1;
    localparam logic [CW-1:0] NP = CW'(NUM_PROCS);
    localparam logic [IW-1:0] IDLE = '0;
    localparam logic [IW-1:0] LASTI = IW'(NUM_PROCS - 1);

    // Table entries are small flops with reset values; exit codes are a plain
    // store with no reset.
    logic [2:0]    pst_reg  [NUM_PROCS];
    logic [31:0]   wake_reg [NUM_PROCS];
    logic [15:0]   slc_reg  [NUM_PROCS];
    logic [31:0]   tot_reg  [NUM_PROCS];
    logic [IW-1:0] par_reg  [NUM_PROCS];
    logic [31:0]   exc_mem  [NUM_PROCS];
    logic [IW-1:0] rdy_mem  [NUM_PROCS];
    logic [IW-1:0] fre_mem  [NUM_PROCS];
    logic [IW-1:0] sus_mem  [NUM_PROCS];

    logic [IW-1:0] rdy_hd_reg, fre_hd_reg, sus_hd_reg;
    logic [CW-1:0] rdy_cnt_reg, fre_cnt_reg, sus_cnt_reg;
    logic          mtx_reg, run_reg;
    logic [IW-1:0] cur_reg, idx_reg;
    logic [31:0]   tick_reg;
    logic [15:0]   slice_cfg_reg;
    logic [7:0]    scale_cfg_reg;
    logic [3:0]    req_reg;
    logic [31:0]   arg_reg, prod_reg;
    logic [1:0]    st_reg;
    logic [31:0]   rv_reg, ev_reg;
    logic [5:0]    rp_reg, rel_reg;
    logic          hit_reg;

    logic [IW-1:0] rdy_tail, fre_tail, sus_tail;
    logic [IW-1:0] rdy_head_id, fre_head_id, sus_head_id, par_cur;
    logic [IW-1:0] rdy_hd_inc, fre_hd_inc, sus_hd_inc;

    assign rdy_tail    = IW'((CW'(rdy_hd_reg) + rdy_cnt_reg) % NP);
    assign fre_tail    = IW'((CW'(fre_hd_reg) + fre_cnt_reg) % NP);
    assign sus_tail    = IW'((CW'(sus_hd_reg) + sus_cnt_reg) % NP);
    assign rdy_hd_inc  = IW'((CW'(rdy_hd_reg) + CW'(1)) % NP);
    assign fre_hd_inc  = IW'((CW'(fre_hd_reg) + CW'(1)) % NP);
    assign sus_hd_inc  = IW'((CW'(sus_hd_reg) + CW'(1)) % NP);
    assign rdy_head_id = rdy_mem[rdy_hd_reg];
    assign fre_head_id = fre_mem[fre_hd_reg];
    assign sus_head_id = sus_mem[sus_hd_reg];
    assign par_cur     = par_reg[cur_reg];

    assign stat.scan_last = (idx_reg == LASTI);
    assign stat.scan_hit  = hit_reg;
    assign stat.running   = run_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_PROCS; i++) begin
                pst_reg[i]  <= ST_FREE;
                wake_reg[i] <= '0;
                slc_reg[i]  <= '0;
                tot_reg[i]  <= '0;
                par_reg[i]  <= '0;
                fre_mem[i]  <= IW'(i);
            end
            rdy_hd_reg <= '0; fre_hd_reg <= '0; sus_hd_reg <= '0;
            rdy_cnt_reg <= '0; fre_cnt_reg <= NP; sus_cnt_reg <= '0;
            mtx_reg <= 1'b0; run_reg <= 1'b0; cur_reg <= '0;
            tick_reg <= '0; idx_reg <= '0; hit_reg <= 1'b0;
            slice_cfg_reg <= SLICE_RESET; scale_cfg_reg <= SCALE_RESET;
        end else begin
            if (cfg_we && cfg_addr == CFG_SLICE) slice_cfg_reg <= cfg_wdata;
            if (cfg_we && cfg_addr == CFG_SCALE) scale_cfg_reg <= cfg_wdata[7:0];
            case (cmd.op)
                OP_LATCH: begin
                    req_reg <= req; arg_reg <= arg;
                    idx_reg <= '0; hit_reg <= 1'b0;
                    st_reg <= STAT_OK; rv_reg <= '0; ev_reg <= '0;
                    rp_reg <= 6'd32; rel_reg <= 6'd32;
                    // sleep length, ready before the syscall step
                    prod_reg <= arg * {24'd0, scale_cfg_reg};
                end
                OP_DISPATCH: begin
                    if (!run_reg) begin
                        if (rdy_cnt_reg != '0) begin
                            cur_reg <= rdy_head_id; run_reg <= 1'b1;
                            pst_reg[rdy_head_id] <= ST_RUN;
                            slc_reg[rdy_head_id] <= '0;
                            rdy_hd_reg <= rdy_hd_inc;
                            rdy_cnt_reg <= rdy_cnt_reg - CW'(1);
                        end else if (pst_reg[IDLE] != ST_FREE) begin
                            cur_reg <= IDLE; run_reg <= 1'b1;
                            pst_reg[IDLE] <= ST_RUN; slc_reg[IDLE] <= '0;
                        end
                    end
                end
                OP_TICK_CHARGE: begin
                    tick_reg <= tick_reg + 32'd1;
                    if (run_reg) begin
                        slc_reg[cur_reg] <= slc_reg[cur_reg] + 16'd1;
                        tot_reg[cur_reg] <= tot_reg[cur_reg] + 32'd1;
                    end
                end
                OP_SCAN: begin
                    // one entry per cycle, index order
                    if (pst_reg[idx_reg] == ST_SLEEP && wake_reg[idx_reg] == tick_reg) begin
                        pst_reg[idx_reg] <= ST_READY;
                        if (rdy_cnt_reg < NP) begin
                            rdy_mem[rdy_tail] <= idx_reg;
                            rdy_cnt_reg <= rdy_cnt_reg + CW'(1);
                        end
                    end
                    if (idx_reg != LASTI) idx_reg <= idx_reg + IW'(1);
                end
                OP_PREEMPT: begin
                    if (run_reg && cur_reg != IDLE && slc_reg[cur_reg] >= slice_cfg_reg) begin
                        if (rdy_cnt_reg < NP) begin
                            rdy_mem[rdy_tail] <= cur_reg;
                            rdy_cnt_reg <= rdy_cnt_reg + CW'(1);
                        end
                        pst_reg[cur_reg] <= ST_READY;
                        run_reg <= 1'b0;
                    end
                end
                OP_SPAWN: begin
                    if (fre_cnt_reg == '0) begin
                        st_reg <= STAT_NO_FREE; rv_reg <= '1;
                    end else begin
                        fre_hd_reg <= fre_hd_inc;
                        fre_cnt_reg <= fre_cnt_reg - CW'(1);
                        wake_reg[fre_head_id] <= '0; slc_reg[fre_head_id] <= '0;
                        tot_reg[fre_head_id] <= '0; par_reg[fre_head_id] <= '0;
                        exc_mem[fre_head_id] <= '0;
                        pst_reg[fre_head_id] <= ST_READY;
                        if (fre_head_id != IDLE && rdy_cnt_reg < NP) begin
                            rdy_mem[rdy_tail] <= fre_head_id;
                            rdy_cnt_reg <= rdy_cnt_reg + CW'(1);
                        end
                        rv_reg <= 32'(fre_head_id);
                    end
                end
                OP_WAIT_SCAN: begin
                    if (pst_reg[idx_reg] == ST_ZOMBIE && par_reg[idx_reg] == cur_reg)
                        hit_reg <= 1'b1;
                    else if (idx_reg != LASTI) idx_reg <= idx_reg + IW'(1);
                end
                OP_SYSCALL: begin
                    if (!run_reg) st_reg <= STAT_NO_RUN;
                    else begin
                        case (req_reg)
                            REQ_GETPID:  rv_reg <= 32'(cur_reg);
                            REQ_GETTIME: rv_reg <= tick_reg;
                            REQ_SLEEP: begin
                                wake_reg[cur_reg] <= tick_reg + prod_reg;
                                pst_reg[cur_reg] <= ST_SLEEP; run_reg <= 1'b0;
                            end
                            REQ_FORK: begin
                                if (fre_cnt_reg == '0) begin
                                    st_reg <= STAT_NO_FREE; rv_reg <= '1;
                                end else begin
                                    fre_hd_reg <= fre_hd_inc;
                                    fre_cnt_reg <= fre_cnt_reg - CW'(1);
                                    if (rdy_cnt_reg < NP) begin
                                        rdy_mem[rdy_tail] <= fre_head_id;
                                        rdy_cnt_reg <= rdy_cnt_reg + CW'(1);
                                    end
                                    wake_reg[fre_head_id] <= wake_reg[cur_reg];
                                    exc_mem[fre_head_id] <= exc_mem[cur_reg];
                                    pst_reg[fre_head_id] <= ST_READY;
                                    slc_reg[fre_head_id] <= '0;
                                    tot_reg[fre_head_id] <= '0;
                                    par_reg[fre_head_id] <= cur_reg;
                                    rv_reg <= 32'(fre_head_id);
                                end
                            end
                            REQ_LOCK: begin
                                if (arg_reg != '0) st_reg <= STAT_BAD_MTX;
                                else if (!mtx_reg) mtx_reg <= 1'b1;
                                else begin
                                    if (sus_cnt_reg < NP) begin
                                        sus_mem[sus_tail] <= cur_reg;
                                        sus_cnt_reg <= sus_cnt_reg + CW'(1);
                                    end
                                    pst_reg[cur_reg] <= ST_SUSPEND; run_reg <= 1'b0;
                                end
                            end
                            REQ_UNLOCK: begin
                                if (arg_reg != '0) st_reg <= STAT_BAD_MTX;
                                else if (sus_cnt_reg != '0) begin
                                    sus_hd_reg <= sus_hd_inc;
                                    sus_cnt_reg <= sus_cnt_reg - CW'(1);
                                    pst_reg[sus_head_id] <= ST_READY;
                                    if (rdy_cnt_reg < NP) begin
                                        rdy_mem[rdy_tail] <= sus_head_id;
                                        rdy_cnt_reg <= rdy_cnt_reg + CW'(1);
                                    end
                                end else mtx_reg <= 1'b0;
                            end
                            REQ_EXIT: begin
                                run_reg <= 1'b0;
                                if (pst_reg[par_cur] == ST_WAIT) begin
                                    pst_reg[par_cur] <= ST_READY;
                                    if (rdy_cnt_reg < NP) begin
                                        rdy_mem[rdy_tail] <= par_cur;
                                        rdy_cnt_reg <= rdy_cnt_reg + CW'(1);
                                    end
                                    rel_reg <= 6'(par_cur); rp_reg <= 6'(cur_reg);
                                    ev_reg <= arg_reg;
                                    pst_reg[cur_reg] <= ST_FREE;
                                    if (fre_cnt_reg < NP) begin
                                        fre_mem[fre_tail] <= cur_reg;
                                        fre_cnt_reg <= fre_cnt_reg + CW'(1);
                                    end
                                end else begin
                                    exc_mem[cur_reg] <= arg_reg;
                                    pst_reg[cur_reg] <= ST_ZOMBIE;
                                end
                            end
                            REQ_WAIT: begin
                                if (!hit_reg) begin
                                    pst_reg[cur_reg] <= ST_WAIT; run_reg <= 1'b0;
                                end else begin
                                    rp_reg <= 6'(idx_reg);
                                    ev_reg <= exc_mem[idx_reg];
                                    pst_reg[idx_reg] <= ST_FREE;
                                    if (fre_cnt_reg < NP) begin
                                        fre_mem[fre_tail] <= idx_reg;
                                        fre_cnt_reg <= fre_cnt_reg + CW'(1);
                                    end
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                OP_REQUEUE: begin
                    if (run_reg) begin
                        pst_reg[cur_reg] <= ST_READY;
                        if (rdy_cnt_reg < NP) begin
                            rdy_mem[rdy_tail] <= cur_reg;
                            rdy_cnt_reg <= rdy_cnt_reg + CW'(1);
                        end
                        run_reg <= 1'b0;
                    end
                end
                OP_FINISH: begin
                    o_status <= st_reg; o_ret_value <= rv_reg; o_ret_pid <= rp_reg;
                    o_exit_value <= ev_reg; o_released_parent <= rel_reg;
                    o_running_id <= run_reg ? 6'(cur_reg) : 6'd32;
                end
                default: ;
            endcase
        end
    end
endmodule
`default_nettype wire

FILE: sv/process_scheduler_event_engine_top.sv
// Top level of the process scheduler event engine.
// Depends on pse_pkg, pse_ctrl, pse_dp and the defines header.
`timescale 1ns / 1ps
`default_nettype none
// Channel   | Dir | Word
// s_axis    | in  | tdata = {arg, req_type}
// m_axis    | out | tdata = {running_id, released_parent, exit_value, ret_pid,
//           |     |          ret_value, status}
// cfg       | in  | write enable, index, 16-bit data
// Steps: a tick checks every process entry for a wake, one entry per cycle in the
// wake scan; wait searches the entries for a zombie child and stops at a hit.
// Reset: aresetn, synchronous, active low; table, queues and counters clear at once.
// Stalls: the result waits in an output register; m_tready low holds it and
// blocks the next word only once the next result is ready.
`include "process_scheduler_event_engine_top_defines.svh"
module process_scheduler_event_engine_top #(
    parameter int NUM_PROCS = 32
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [39:0] s_tdata,   // [3:0] req_type, [35:4] arg, [39:36] zero
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [111:0] m_tdata,  // [1:0] status, [33:2] ret_value, [39:34] ret_pid,
                                   // [71:40] exit_value, [77:72] released_parent,
                                   // [83:78] running_id, [111:84] zero
    input  wire         cfg_we,
    input  wire  [0:0]  cfg_addr,
    input  wire  [15:0] cfg_wdata
);
    import pse_pkg::*;

    pse_cmd_t    cmd;
    pse_stat_t   stat;
    logic [1:0]  o_status;
    logic [31:0] o_ret_value, o_exit_value;
    logic [5:0]  o_ret_pid, o_released_parent, o_running_id;

    // Sequence each word through its steps.
    pse_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .in_valid(s_tvalid), .in_ready(s_tready),
        .req(s_tdata[3:0]), .out_valid(m_tvalid), .out_ready(m_tready),
        .stat(stat), .cmd(cmd)
    );

    // Hold the process table and queues.
    pse_dp #(.NUM_PROCS(NUM_PROCS)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .stat(stat),
        .req(s_tdata[3:0]), .arg(s_tdata[35:4]),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .o_status(o_status), .o_ret_value(o_ret_value), .o_ret_pid(o_ret_pid),
        .o_exit_value(o_exit_value), .o_released_parent(o_released_parent),
        .o_running_id(o_running_id)
    );

    assign m_tdata = {28'd0, o_running_id, o_released_parent, o_exit_value,
                      o_ret_pid, o_ret_value, o_status};

    `PSE_ASSERT_NEXT(a_word_taken, aclk, aresetn, s_tvalid && s_tready, !s_tready,
        "input accepted twice in a row")
    `PSE_ASSERT_IMPL(a_run_range, aclk, aresetn, m_tvalid,
        m_tdata[83:78] <= 6'd32, "running id out of range")
    `PSE_ASSERT_IMPL(a_no_run_status, aclk, aresetn,
        m_tvalid && m_tdata[1:0] == STAT_NO_RUN, m_tdata[83:78] == 6'd32,
        "no-running status with a running id")
endmodule
`default_nettype wire

FILE: sim/tb_process_scheduler_event_engine_top.sv
// Self-checking testbench for the process scheduler event engine top level.
// Depends on pse_pkg and process_scheduler_event_engine_top; drives events, predicts each result.
`timescale 1ns / 1ps
`default_nettype none
module tb_process_scheduler_event_engine_top;
    import pse_pkg::*;

    localparam int NPROC     = 32;
    localparam logic [5:0] NO_ID = 6'd32;
    localparam int CYC_LIMIT = 2000000;
    localparam int N_DIRECT  = 22;
    localparam int N_RANDOM  = 728;

    // One result word, unpacked.
    typedef struct packed {
        logic [5:0]  running_id;
        logic [5:0]  released_parent;
        logic [31:0] exit_value;
        logic [5:0]  ret_pid;
        logic [31:0] ret_value;
        logic [1:0]  status;
    } sched_result_t;

    // Directed row: event, argument, and an optional hand-typed result.
    typedef struct {
        logic [3:0]    req;
        logic [31:0]   arg;
        bit            typed;
        sched_result_t want;
    } event_row_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [39:0]  s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [111:0] m_tdata;
    logic         cfg_we = 1'b0;
    logic [0:0]   cfg_addr = CFG_SLICE;
    logic [15:0]  cfg_wdata = '0;

    int  err_count = 0;
    int  cycle_count = 0;
    int  sent_count = 0;
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;

    // Shadow scheduler state.
    logic [2:0]  pstate [NPROC];
    logic [31:0] wake_tick [NPROC];
    logic [15:0] slice_cnt [NPROC];
    logic [31:0] run_ticks [NPROC];
    logic [4:0]  parent_of [NPROC];
    logic [31:0] exit_stash [NPROC];
    logic [4:0]  ready_q [$];
    logic [4:0]  free_q [$];
    logic [4:0]  suspend_q [$];
    bit          mutex_held;
    logic [5:0]  running;
    logic [31:0] tick_now;
    logic [15:0] slice_limit;
    logic [7:0]  sleep_mult;

    sched_result_t result_q [$];
    event_row_t    rows [N_DIRECT];

    process_scheduler_event_engine_top #(.NUM_PROCS(NPROC)) DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    always #1 aclk = ~aclk;

    // Watchdog: end the run if something hangs.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYC_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %0h want %0h at cycle %0d", what, got, want, cycle_count);
        err_count++;
    endtask

    function automatic void clear_shadow();
        for (int i = 0; i < NPROC; i++) begin
            pstate[i] = ST_FREE; wake_tick[i] = '0; slice_cnt[i] = '0;
            run_ticks[i] = '0; parent_of[i] = '0; exit_stash[i] = '0;
        end
        ready_q.delete(); suspend_q.delete(); free_q.delete();
        for (int i = 0; i < NPROC; i++) free_q.push_back(5'(i));
        mutex_held = 0; running = NO_ID; tick_now = '0;
        slice_limit = SLICE_RESET; sleep_mult = SCALE_RESET;
    endfunction

    // Queue puts drop the id when the queue is full.
    function automatic void put_ready(input logic [4:0] id);
        if (ready_q.size() < NPROC) ready_q.push_back(id);
    endfunction

    // Advance the shadow scheduler by one event and return what it reports.
    function automatic sched_result_t schedule_event(input logic [3:0] req,
                                                     input logic [31:0] arg);
        sched_result_t r;
        logic [5:0] cur;
        logic [4:0] id;
        int hit;
        r = '{status: STAT_OK, ret_value: '0, ret_pid: NO_ID, exit_value: '0,
              released_parent: NO_ID, running_id: NO_ID};
        cur = running;
        if (req == REQ_DISPATCH) begin
            if (cur == NO_ID) begin
                if (ready_q.size() > 0) running = {1'b0, ready_q.pop_front()};
                else if (pstate[0] != ST_FREE) running = 6'd0;
                if (running != NO_ID) begin
                    pstate[running[4:0]] = ST_RUN;
                    slice_cnt[running[4:0]] = '0;
                end
            end
        end else if (req == REQ_TICK) begin
            tick_now++;
            if (cur != NO_ID) begin
                slice_cnt[cur[4:0]]++;
                run_ticks[cur[4:0]]++;
            end
            for (int i = 0; i < NPROC; i++)
                if (pstate[i] == ST_SLEEP && wake_tick[i] == tick_now) begin
                    pstate[i] = ST_READY;
                    put_ready(5'(i));
                end
            if (cur != NO_ID && cur != 6'd0 && slice_cnt[cur[4:0]] >= slice_limit) begin
                put_ready(cur[4:0]);
                pstate[cur[4:0]] = ST_READY;
                running = NO_ID;
            end
        end else if (req == REQ_SPAWN) begin
            if (free_q.size() == 0) begin
                r.status = STAT_NO_FREE; r.ret_value = '1;
            end else begin
                id = free_q.pop_front();
                wake_tick[id] = '0; slice_cnt[id] = '0; run_ticks[id] = '0;
                parent_of[id] = '0; exit_stash[id] = '0; pstate[id] = ST_READY;
                if (id != 5'd0) put_ready(id);
                r.ret_value = 32'(id);
            end
        end else if (req <= REQ_WAIT) begin
            if (cur == NO_ID) begin
                r.status = STAT_NO_RUN;
            end else begin
                case (req)
                    REQ_GETPID:  r.ret_value = 32'(cur);
                    REQ_GETTIME: r.ret_value = tick_now;
                    REQ_SLEEP: begin
                        wake_tick[cur[4:0]] = tick_now + arg * 32'(sleep_mult);
                        pstate[cur[4:0]] = ST_SLEEP;
                        running = NO_ID;
                    end
                    REQ_FORK: begin
                        if (free_q.size() == 0) begin
                            r.status = STAT_NO_FREE; r.ret_value = '1;
                        end else begin
                            id = free_q.pop_front();
                            put_ready(id);
                            wake_tick[id] = wake_tick[cur[4:0]];
                            exit_stash[id] = exit_stash[cur[4:0]];
                            pstate[id] = ST_READY; slice_cnt[id] = '0;
                            run_ticks[id] = '0; parent_of[id] = cur[4:0];
                            r.ret_value = 32'(id);
                        end
                    end
                    REQ_LOCK: begin
                        if (arg != 0) r.status = STAT_BAD_MTX;
                        else if (!mutex_held) mutex_held = 1;
                        else begin
                            if (suspend_q.size() < NPROC) suspend_q.push_back(cur[4:0]);
                            pstate[cur[4:0]] = ST_SUSPEND;
                            running = NO_ID;
                        end
                    end
                    REQ_UNLOCK: begin
                        if (arg != 0) r.status = STAT_BAD_MTX;
                        else if (suspend_q.size() > 0) begin
                            id = suspend_q.pop_front();
                            pstate[id] = ST_READY;
                            put_ready(id);
                        end else mutex_held = 0;
                    end
                    REQ_EXIT: begin
                        id = parent_of[cur[4:0]];
                        if (pstate[id] == ST_WAIT) begin
                            pstate[id] = ST_READY;
                            put_ready(id);
                            r.released_parent = {1'b0, id};
                            r.ret_pid = cur;
                            r.exit_value = arg;
                            pstate[cur[4:0]] = ST_FREE;
                            if (free_q.size() < NPROC) free_q.push_back(cur[4:0]);
                        end else begin
                            exit_stash[cur[4:0]] = arg;
                            pstate[cur[4:0]] = ST_ZOMBIE;
                        end
                        running = NO_ID;
                    end
                    default: begin
                        hit = -1;
                        for (int i = 0; i < NPROC; i++)
                            if (hit < 0 && pstate[i] == ST_ZOMBIE && parent_of[i] == cur[4:0])
                                hit = i;
                        if (hit < 0) begin
                            pstate[cur[4:0]] = ST_WAIT;
                            running = NO_ID;
                        end else begin
                            r.ret_pid = 6'(hit);
                            r.exit_value = exit_stash[hit];
                            pstate[hit] = ST_FREE;
                            if (free_q.size() < NPROC) free_q.push_back(5'(hit));
                        end
                    end
                endcase
                // A caller still running goes to the back of the ready queue.
                if (running != NO_ID) begin
                    pstate[running[4:0]] = ST_READY;
                    put_ready(running[4:0]);
                    running = NO_ID;
                end
            end
        end
        r.running_id = running;
        return r;
    endfunction

    // Check every accepted result word against the oldest expectation.
    always @(posedge aclk) begin
        sched_result_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[83:0];
            if (result_q.size() == 0) begin
                report_mismatch("unexpected result word", 32'd1, 32'd0);
            end else begin
                want = result_q.pop_front();
                if (got.status != want.status)
                    report_mismatch("status", 32'(got.status), 32'(want.status));
                if (got.ret_value != want.ret_value)
                    report_mismatch("ret_value", got.ret_value, want.ret_value);
                if (got.ret_pid != want.ret_pid)
                    report_mismatch("ret_pid", 32'(got.ret_pid), 32'(want.ret_pid));
                if (got.exit_value != want.exit_value)
                    report_mismatch("exit_value", got.exit_value, want.exit_value);
                if (got.released_parent != want.released_parent)
                    report_mismatch("released_parent", 32'(got.released_parent),
                                    32'(want.released_parent));
                if (got.running_id != want.running_id)
                    report_mismatch("running_id", 32'(got.running_id),
                                    32'(want.running_id));
            end
        end
    end

    // Randomly stall the result side at the falling edge.
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Send one event word; hold it until accepted, then predict its result.
    // Valid stays high into the next call; idling or a drain drops it.
    task automatic send_event(input logic [3:0] req, input logic [31:0] arg,
                              input bit typed, input sched_result_t want);
        sched_result_t pred;
        if ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
            while ($urandom_range(99) < send_idle_pct) @(negedge aclk);
        end
        s_tdata <= {4'b0, arg, req};
        s_tvalid <= 1'b1;
        sent_count++;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pred = schedule_event(req, arg);
        if (typed && pred != want)
            report_mismatch("directed row vs prediction", pred[31:0], want[31:0]);
        result_q.push_back(pred);
        @(negedge aclk);
    endtask

    // Wait for all expected words, then let the block settle before a write.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (result_q.size() > 0) @(negedge aclk);
        repeat (NPROC + 10) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [0:0] idx, input logic [15:0] val);
        cfg_we <= 1'b1; cfg_addr <= idx; cfg_wdata <= val;
        @(negedge aclk);
        cfg_we <= 1'b0;
        if (idx == CFG_SLICE) slice_limit = val;
        else sleep_mult = val[7:0];
        @(negedge aclk);
    endtask

    function automatic event_row_t mk(input logic [3:0] req, input logic [31:0] arg);
        return '{req: req, arg: arg, typed: 0, want: '0};
    endfunction

    function automatic event_row_t mk_typed(input logic [3:0] req, input logic [31:0] arg,
                                             input logic [1:0] st, input logic [31:0] rv,
                                             input logic [5:0] run_id);
        return '{req: req, arg: arg, typed: 1,
                 want: '{status: st, ret_value: rv, ret_pid: NO_ID, exit_value: '0,
                         released_parent: NO_ID, running_id: run_id}};
    endfunction

    // Pick an event, mostly syscalls on a live process with valid arguments.
    task automatic random_event();
        int pick;
        logic [3:0] req;
        logic [31:0] arg;
        pick = $urandom_range(99);
        arg = 32'd0;
        if (pick < 18)      req = REQ_DISPATCH;
        else if (pick < 34) req = REQ_TICK;
        else if (pick < 42) req = REQ_SPAWN;
        else if (pick < 45) req = 4'($urandom_range(15, 11));
        else req = 4'($urandom_range(REQ_WAIT, REQ_GETPID));
        case (req)
            REQ_SLEEP: arg = ($urandom_range(9) == 0) ? $urandom() : 32'($urandom_range(3));
            REQ_LOCK, REQ_UNLOCK: arg = ($urandom_range(7) == 0) ? $urandom() : 32'd0;
            REQ_EXIT: arg = $urandom();
            default:  arg = ($urandom_range(3) == 0) ? $urandom() : 32'd0;
        endcase
        // A syscall needs a running process; dispatch first most of the time.
        if (req >= REQ_GETPID && running == NO_ID && $urandom_range(9) != 0)
            send_event(REQ_DISPATCH, 32'd0, 0, '0);
        send_event(req, arg, 0, '0);
    endtask

    initial begin
        clear_shadow();
        // Directed rows: empty scheduler, extremes of arg, every event type.
        rows[0]  = mk_typed(REQ_DISPATCH, 32'd0, STAT_OK, 32'd0, NO_ID);
        rows[1]  = mk_typed(REQ_GETPID, 32'd0, STAT_NO_RUN, 32'd0, NO_ID);
        rows[2]  = mk_typed(REQ_TICK, 32'hFFFF_FFFF, STAT_OK, 32'd0, NO_ID);
        rows[3]  = mk_typed(REQ_SPAWN, 32'd0, STAT_OK, 32'd0, NO_ID);
        rows[4]  = mk_typed(REQ_SPAWN, 32'h8000_0000, STAT_OK, 32'd1, NO_ID);
        rows[5]  = mk_typed(REQ_DISPATCH, 32'd0, STAT_OK, 32'd0, 6'd1);
        rows[6]  = mk(REQ_DISPATCH, 32'd0);
        rows[7]  = mk(REQ_GETTIME, 32'd0);
        rows[8]  = mk(REQ_DISPATCH, 32'd0);
        rows[9]  = mk(REQ_LOCK, 32'd0);
        rows[10] = mk(REQ_DISPATCH, 32'd0);
        rows[11] = mk(REQ_LOCK, 32'h7FFF_FFFF);
        rows[12] = mk(REQ_DISPATCH, 32'd0);
        rows[13] = mk(REQ_FORK, 32'd0);
        rows[14] = mk(REQ_DISPATCH, 32'd0);
        rows[15] = mk(REQ_WAIT, 32'd0);
        rows[16] = mk(REQ_DISPATCH, 32'd0);
        rows[17] = mk(REQ_EXIT, 32'h8000_0000);
        rows[18] = mk(REQ_DISPATCH, 32'd0);
        rows[19] = mk(REQ_SLEEP, 32'h7FFF_FFFF);
        rows[20] = mk_typed(4'd15, 32'hFFFF_FFFF, STAT_OK, 32'd0, NO_ID);
        rows[21] = mk(REQ_UNLOCK, 32'd0);

        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (rows[i]) send_event(rows[i].req, rows[i].arg, rows[i].typed, rows[i].want);

        // Random phases, each under its own register setting, with varied idling mixes.
        for (int phase = 0; phase < 5; phase++) begin
            drain_results();
            // The first reset pulse was the only one; return to a known scheduler
            // by keeping the shadow and just rewriting registers.
            case (phase)
                0: begin write_reg(CFG_SLICE, 16'd1);     write_reg(CFG_SCALE, 8'd1);   end
                1: begin write_reg(CFG_SLICE, 16'd65535); write_reg(CFG_SCALE, 8'd255); end
                2: begin write_reg(CFG_SLICE, 16'd3);     write_reg(CFG_SCALE, 8'd2);   end
                3: begin write_reg(CFG_SLICE, 16'd2);     write_reg(CFG_SCALE, 8'd1);   end
                default: begin write_reg(CFG_SLICE, 16'd4); write_reg(CFG_SCALE, 8'd3); end
            endcase
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 88; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 88; end
                3: begin send_idle_pct = 36; recv_stall_pct = 36; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            while (sent_count < N_DIRECT + ((phase + 1) * N_RANDOM) / 5) random_event();
        end

        drain_results();
        if (err_count == 0) $display("PASS");
        else $display("FAIL");
        $finish;
    end
endmodule
`default_nettype wire

FILE: process_scheduler_event_engine_top.f
+incdir+sv
sv/pse_pkg.sv
sv/pse_ctrl.sv
sv/pse_dp.sv
sv/process_scheduler_event_engine_top.sv
sim/tb_process_scheduler_event_engine_top.sv
